// ===== rtl/d2cc_pkg.sv =====
// shared constants, item codes and memory request types for the
// distance-2 colouring conflict checker; no dependencies
`default_nettype none

package d2cc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 8192;
  localparam int COLOR_BITS   = 16;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 16;
  localparam int ROW_W   = 14;
  localparam int ADJ_W   = 10;
  localparam int OUTV_W  = 10;
  localparam int COUNT_W = 11;

  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int RADDR_W = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_ROW   = 3'd0,
    MODE_ADJ   = 3'd1,
    MODE_COLOR = 3'd2,
    MODE_CHECK = 3'd3,
    MODE_START = 3'd4
  } mode_t;

  typedef struct packed {
    logic               we;
    logic [RADDR_W-1:0] addr;
    logic [ROW_W-1:0]   wdata;
  } row_req_t;

  typedef struct packed {
    logic              we;
    logic [EIDX_W-1:0] addr;
    logic [ADJ_W-1:0]  wdata;
  } adj_req_t;

  typedef struct packed {
    logic                  we;
    logic [VTX_W-1:0]      addr;
    logic [COLOR_BITS-1:0] wdata;
  } col_req_t;

  typedef struct packed {
    logic             valid;
    logic             clear;
    logic             hit;
    logic [VTX_W-1:0] vertex;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/d2cc_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module d2cc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/d2cc_ctrl.sv =====
// sequencer: decodes input transfers, drives the three memories and walks
// the two-level neighbour scan through one shared compare; uses d2cc_pkg
`default_nettype none

module d2cc_ctrl
  import d2cc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [MODE_W-1:0]      in_mode,
  input  wire logic [INDEX_W-1:0]     in_index,
  input  wire logic [VALUE_W-1:0]     in_value,
  output row_req_t                    row_req,
  output adj_req_t                    adj_req,
  output col_req_t                    col_req,
  input  wire logic [ROW_W-1:0]       row_rdata,
  input  wire logic [ADJ_W-1:0]       adj_rdata,
  input  wire logic [COLOR_BITS-1:0]  col_rdata,
  input  wire logic                   res_free,
  output res_t                        res
);

  typedef enum logic [3:0] {
    S_IDLE, S_R0, S_R1, S_R2, S_A1, S_A2, S_A3,
    S_B1, S_B2, S_B3, S_B4, S_C1, S_C2, S_C3, S_DONE
  } state_t;

  state_t                state_r;
  logic [VTX_W-1:0]      u_r;
  logic [VTX_W-1:0]      v_r;
  logic [COLOR_BITS-1:0] uc_r;
  logic [ROW_W-1:0]      a_r;
  logic [ECNT_W-1:0]     lou_r, hiu_r, i_r, j_r, hi2_r;
  logic                  hit_r;

  logic                  in_acc;
  logic [ECNT_W-1:0]     end_c, lo_c;
  logic                  v_ok, cand_ok, col_eq;

  function automatic logic [ECNT_W-1:0] clamp_end(logic [ROW_W-1:0] d);
    if (int'(d) > MAX_EDGES) begin
      return ECNT_W'(MAX_EDGES);
    end
    return ECNT_W'(d);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign end_c     = clamp_end(row_rdata);
  assign lo_c      = (int'(a_r) >= int'(end_c)) ? end_c : ECNT_W'(a_r);
  assign v_ok      = int'(adj_rdata) < MAX_VERTICES;
  assign cand_ok   = v_ok && (int'(adj_rdata) < int'(u_r));
  assign col_eq    = (col_rdata == uc_r);

  always_comb begin
    row_req = '{we: 1'b0, addr: RADDR_W'(u_r), wdata: in_value[ROW_W-1:0]};
    adj_req = '{we: 1'b0, addr: i_r[EIDX_W-1:0], wdata: in_value[ADJ_W-1:0]};
    col_req = '{we: 1'b0, addr: u_r,
                wdata: COLOR_BITS'(signed'(in_value))};
    res     = '{valid: 1'b0, clear: 1'b0, hit: hit_r, vertex: u_r};
    unique case (state_r)
      S_IDLE: begin
        row_req.addr = in_index[RADDR_W-1:0];
        adj_req.addr = in_index[EIDX_W-1:0];
        col_req.addr = in_index[VTX_W-1:0];
        row_req.we   = in_acc && (in_mode == MODE_ROW) &&
                       (int'(in_index) <= MAX_VERTICES);
        adj_req.we   = in_acc && (in_mode == MODE_ADJ) &&
                       (int'(in_index) < MAX_EDGES);
        col_req.we   = in_acc && (in_mode == MODE_COLOR) &&
                       (int'(in_index) < MAX_VERTICES);
        res.clear    = in_acc && (in_mode == MODE_START);
      end
      S_R0: ;
      S_R1: row_req.addr = RADDR_W'(int'(u_r) + 1);
      S_R2: ;
      S_A1: adj_req.addr = i_r[EIDX_W-1:0];
      S_A2: col_req.addr = VTX_W'(adj_rdata);
      S_A3: ;
      S_B1: adj_req.addr = i_r[EIDX_W-1:0];
      S_B2: row_req.addr = RADDR_W'(adj_rdata);
      S_B3: row_req.addr = RADDR_W'(int'(v_r) + 1);
      S_B4: ;
      S_C1: adj_req.addr = j_r[EIDX_W-1:0];
      S_C2: col_req.addr = VTX_W'(adj_rdata);
      S_C3: ;
      S_DONE: begin
        col_req.wdata = '1;
        col_req.we    = hit_r && res_free;
        res.valid     = res_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_mode == MODE_CHECK) &&
              (int'(in_index) < MAX_VERTICES)) begin
            u_r     <= in_index[VTX_W-1:0];
            hit_r   <= 1'b0;
            state_r <= S_R0;
          end
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          a_r     <= row_rdata;
          uc_r    <= col_rdata;
          state_r <= S_R2;
        end
        S_R2: begin
          lou_r   <= lo_c;
          i_r     <= lo_c;
          hiu_r   <= end_c;
          state_r <= S_A1;
        end
        S_A1: begin
          if (i_r >= hiu_r) begin
            i_r     <= lou_r;
            state_r <= S_B1;
          end else begin
            state_r <= S_A2;
          end
        end
        S_A2: begin
          if (cand_ok) begin
            state_r <= S_A3;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_A1;
          end
        end
        S_A3: begin
          if (col_eq) begin
            hit_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_A1;
          end
        end
        S_B1: state_r <= (i_r >= hiu_r) ? S_DONE : S_B2;
        S_B2: begin
          if (v_ok) begin
            v_r     <= VTX_W'(adj_rdata);
            state_r <= S_B3;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_B1;
          end
        end
        S_B3: begin
          a_r     <= row_rdata;
          state_r <= S_B4;
        end
        S_B4: begin
          j_r     <= lo_c;
          hi2_r   <= end_c;
          state_r <= S_C1;
        end
        S_C1: begin
          if (j_r >= hi2_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_B1;
          end else begin
            state_r <= S_C2;
          end
        end
        S_C2: begin
          if (cand_ok) begin
            state_r <= S_C3;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_C1;
          end
        end
        S_C3: begin
          if (col_eq) begin
            hit_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_C1;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a valid check always leaves idle for the scan
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_CHECK) && (int'(in_index) < MAX_VERTICES)
    |=> !in_tready)
    else $error("check transfer did not start a scan");

  // a result is only issued when the output stage can take it
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> res_free && !res.clear)
    else $error("result issued into a full output stage");

  // uncolouring write only follows a detected hit
  a_uncolour: assert property (@(posedge clk) disable iff (!rst_n)
    col_req.we && !in_tready |-> hit_r && res.valid)
    else $error("colour overwritten without a conflict");

  // scan index never runs past the end of the row
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A2 || state_r == S_B2) |-> i_r < hiu_r)
    else $error("scan index beyond row end");

endmodule

`default_nettype wire

// ===== rtl/distance2_coloring_conflict_check_unit.sv =====
// top level: memories for row starts, adjacency and colours, the scan
// sequencer, conflict counter and output register; uses d2cc_pkg, d2cc_ram, d2cc_ctrl
`default_nettype none

// Load items (row start, adjacency entry, colour) and start-pass items are
// taken while idle and give no result. A check item of vertex u reads u's
// row bounds and colour, then walks every entry of u's row and reads the
// colour of each entry that is a lower candidate, then closes the row; then
// for every neighbour it fetches that row's bounds, walks its entries the
// same way and closes it; then it closes the neighbour walk and issues the
// result, held for as long as the output register stays full. The scan stops
// at the first hit. All work goes through single-port memories with
// registered reads, one access a cycle. No item is taken while a check runs.
// The memories need no clearing after reset.
module distance2_coloring_conflict_check_unit
  import d2cc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // index[12:0], value[28:13]
  input  wire logic [MODE_W-1:0]      in_tuser,   // mode[2:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // vertex[9:0], conflict[10],
                                                  // conflict_count[21:11]
);

  row_req_t              row_req;
  adj_req_t              adj_req;
  col_req_t              col_req;
  logic [ROW_W-1:0]      row_rdata;
  logic [ADJ_W-1:0]      adj_rdata;
  logic [COLOR_BITS-1:0] col_rdata;
  res_t                  res;
  logic                  res_free;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  d2cc_ram #(.DEPTH(MAX_VERTICES + 1), .WIDTH(ROW_W)) u_row_mem (
    .clk   (clk),
    .we    (row_req.we),
    .addr  (row_req.addr),
    .wdata (row_req.wdata),
    .rdata (row_rdata)
  );

  d2cc_ram #(.DEPTH(MAX_EDGES), .WIDTH(ADJ_W)) u_adj_mem (
    .clk   (clk),
    .we    (adj_req.we),
    .addr  (adj_req.addr),
    .wdata (adj_req.wdata),
    .rdata (adj_rdata)
  );

  d2cc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(COLOR_BITS)) u_col_mem (
    .clk   (clk),
    .we    (col_req.we),
    .addr  (col_req.addr),
    .wdata (col_req.wdata),
    .rdata (col_rdata)
  );

  d2cc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_index  (in_tdata[INDEX_W-1:0]),
    .in_value  (in_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .row_req   (row_req),
    .adj_req   (adj_req),
    .col_req   (col_req),
    .row_rdata (row_rdata),
    .adj_rdata (adj_rdata),
    .col_rdata (col_rdata),
    .res_free  (res_free),
    .res       (res)
  );

  assign res_free = !out_valid_r || out_tready;

  // saturating count of conflicts
  always_comb begin
    count_nxt = count_r;
    if (res.hit && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (res.clear) begin
        count_r <= '0;
      end else if (res.valid) begin
        count_r <= count_nxt;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= {(OUT_TDATA_W - OUTV_W - 1 - COUNT_W)'(0), count_nxt, res.hit,
                     OUTV_W'(res.vertex)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for distance2_coloring_conflict_check_unit: directed table,
// then random graph blocks checked against a local distance-2 conflict predictor
// depends on d2cc_pkg and the unit under test only
module tb_top
  import d2cc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_MAX = 2**INDEX_W - 1;
  localparam int VALUE_MAX = 2**(VALUE_W-1) - 1;
  localparam int ROW_LIMIT = 2**ROW_W - 1;
  localparam int STALL_LIMIT = 40000;
  localparam int RX_HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 64;
  localparam int BLOCKS_PER_PHASE = 5;
  localparam int TX_IDLE [3] = '{29, 82, 0};
  localparam int RX_IDLE [3] = '{82, 29, 0};
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(MODE_START + 1);
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               conflict;
    logic [OUTV_W-1:0]  vertex;
  } check_result_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    check_result_t      result;
  } stimulus_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // index[12:0], value[28:13]
  logic [MODE_W-1:0] in_tuser;       // mode[2:0]
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata; // vertex[9:0], conflict[10], conflict_count[21:11]

  // predictor copy of the graph, colours and running count
  logic [ROW_W-1:0] row_mem [0:MAX_VERTICES] = '{default: '0};
  logic [ADJ_W-1:0] adj_mem [0:MAX_EDGES-1] = '{default: '0};
  logic [COLOR_BITS-1:0] colour_mem [0:MAX_VERTICES-1] = '{default: '0};
  logic [COUNT_W-1:0] conflicts_so_far = '0;

  check_result_t pending_checks[$];
  stimulus_row_t stimulus_rows[$];
  check_result_t want, got;
  int error_count = 0;
  int stall_cycles = 0;
  int tx_idle_pct, rx_idle_pct;
  bit rx_hold_req = 1'b0;

  distance2_coloring_conflict_check_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void row_bounds(input int v, output int lo, output int hi);
    hi = int'(row_mem[v + 1]);
    lo = int'(row_mem[v]);
    if (hi > MAX_EDGES) hi = MAX_EDGES;
    if (lo >= hi) lo = hi;
  endfunction

  // neighbours first, then neighbours of neighbours; first lower match wins
  function automatic bit find_distance2_clash(input int u);
    int lo, hi, lo2, hi2, v, w;
    logic [COLOR_BITS-1:0] uc;
    uc = colour_mem[u];
    row_bounds(u, lo, hi);
    for (int i = lo; i < hi; i++) begin
      v = int'(adj_mem[i]);
      if (v < MAX_VERTICES && v < u && colour_mem[v] == uc) return 1'b1;
    end
    for (int i = lo; i < hi; i++) begin
      v = int'(adj_mem[i]);
      if (v < MAX_VERTICES) begin
        row_bounds(v, lo2, hi2);
        for (int j = lo2; j < hi2; j++) begin
          w = int'(adj_mem[j]);
          if (w < MAX_VERTICES && w < u && colour_mem[w] == uc) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit colouring_step(input logic [MODE_W-1:0] mode,
                                        input logic [INDEX_W-1:0] index,
                                        input logic [VALUE_W-1:0] value,
                                        output check_result_t res);
    bit produced, hit;
    produced = 1'b0;
    res = '0;
    case (mode)
      MODE_ROW: if (index <= MAX_VERTICES) row_mem[index] = value[ROW_W-1:0];
      MODE_ADJ: if (index < MAX_EDGES) adj_mem[index] = value[ADJ_W-1:0];
      MODE_COLOR: if (index < MAX_VERTICES) colour_mem[index] = COLOR_BITS'($signed(value));
      MODE_CHECK: if (index < MAX_VERTICES) begin
        hit = find_distance2_clash(int'(index));
        if (hit) begin
          colour_mem[index] = '1;
          if (conflicts_so_far != COUNT_SAT) conflicts_so_far++;
        end
        res.vertex = index[OUTV_W-1:0];
        res.conflict = hit;
        res.count = conflicts_so_far;
        produced = 1'b1;
      end
      MODE_START: conflicts_so_far = '0;
      default: ;
    endcase
    return produced;
  endfunction

  function automatic logic [VALUE_W-1:0] any_value();
    if ($urandom_range(7) == 0) return ALL_ONES;
    return VALUE_W'($urandom_range(VALUE_MAX));
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] mode, input int index,
                                  input logic [VALUE_W-1:0] value, input bit typed = 1'b0,
                                  input check_result_t result = '0);
    stimulus_rows.push_back('{mode, INDEX_W'(index), value, typed, result});
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
                           input logic [VALUE_W-1:0] value, input bit typed = 1'b0,
                           input check_result_t typed_result = '0);
    check_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {{(IN_TDATA_W-INDEX_W-VALUE_W){1'b0}}, value, index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (colouring_step(mode, index, value, predicted))
      pending_checks.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk);
  endtask

  // items the block must ignore: unused modes, out-of-range slots and vertices
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_item(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                   INDEX_W'($urandom_range(INDEX_MAX)), any_value());
      1: send_item(MODE_ROW, INDEX_W'($urandom_range(MAX_VERTICES + 1, INDEX_MAX)),
                   any_value());
      2: send_item(MODE_COLOR, INDEX_W'($urandom_range(MAX_VERTICES, INDEX_MAX)),
                   any_value());
      default: send_item(MODE_CHECK, INDEX_W'($urandom_range(MAX_VERTICES, INDEX_MAX)),
                         any_value());
    endcase
  endtask

  // one contiguous vertex range with its own adjacency region, fully written before checks
  task automatic run_block(input bit wide, input bit hold);
    int n, span, b, e0, d, ncolours, nchecks;
    int offs[$];
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] base;
    n = wide ? $urandom_range(16, 32) : $urandom_range(2, 10);
    span = wide ? $urandom_range(24, 40) : $urandom_range(1, 16);
    case ($urandom_range(4))
      0: b = 0;
      1: b = MAX_VERTICES - n;
      default: b = $urandom_range(MAX_VERTICES - n);
    endcase
    case ($urandom_range(4))
      0: e0 = 0;
      1: e0 = MAX_EDGES - span;
      default: e0 = $urandom_range(MAX_EDGES - span);
    endcase
    for (int k = 0; k <= n; k++) offs.push_back(e0 + $urandom_range(span));
    if ($urandom_range(9) < 7) offs.sort();
    for (int k = 0; k <= n; k++) begin
      d = offs[k];
      if (e0 + span == MAX_EDGES && $urandom_range(4) == 0)
        d = $urandom_range(MAX_EDGES + 1, ROW_LIMIT);
      if (d == ROW_LIMIT && $urandom_range(1) == 1) raw = ALL_ONES;
      else raw = VALUE_W'(d) | (VALUE_W'($urandom_range(1)) << ROW_W);
      send_item(MODE_ROW, INDEX_W'(b + k), raw);
    end
    for (int i = e0; i < e0 + span; i++) begin
      d = b + $urandom_range(n - 1);
      if (d == MAX_VERTICES - 1 && $urandom_range(1) == 1) raw = ALL_ONES;
      else raw = VALUE_W'(d) | (VALUE_W'($urandom_range(31)) << ADJ_W);
      send_item(MODE_ADJ, INDEX_W'(i), raw);
    end
    ncolours = $urandom_range(1, 4);
    case ($urandom_range(3))
      0: base = '0;
      1: base = VALUE_W'(VALUE_MAX - 3);
      default: base = VALUE_W'($urandom_range(VALUE_MAX - 3));
    endcase
    for (int k = 0; k < n; k++)
      send_item(MODE_COLOR, INDEX_W'(b + k),
                ($urandom_range(6) == 0) ? ALL_ONES : base + VALUE_W'($urandom_range(ncolours - 1)));
    nchecks = wide ? $urandom_range(8, 16) : $urandom_range(n, 2 * n);
    if (hold) rx_hold_req = 1'b1;
    repeat (nchecks) begin
      case ($urandom_range(19))
        0, 1: send_item(MODE_COLOR, INDEX_W'(b + $urandom_range(n - 1)),
                        ($urandom_range(3) == 0) ? ALL_ONES
                                                 : base + VALUE_W'($urandom_range(ncolours - 1)));
        2: send_item(MODE_START, INDEX_W'($urandom_range(INDEX_MAX)), any_value());
        3: send_noise();
        default: ;
      endcase
      send_item(MODE_CHECK, INDEX_W'(b + $urandom_range(n - 1)), any_value());
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = check_result_t'(out_tdata[$bits(check_result_t)-1:0]);
      if (pending_checks.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_checks.pop_front();
        if (got.vertex !== want.vertex) begin
          $display("%0t: vertex expected %0d got %0d", $time, want.vertex, got.vertex);
          error_count++;
        end
        if (got.conflict !== want.conflict) begin
          $display("%0t: conflict expected %0d got %0d (vertex %0d)", $time,
                   want.conflict, got.conflict, want.vertex);
          error_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: conflict_count expected %0d got %0d (vertex %0d)", $time,
                   want.count, got.count, want.vertex);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    tx_idle_pct = TX_IDLE[0];
    rx_idle_pct = RX_IDLE[0];

    // path 0-1-2, stored-width truncation, ignored items, top vertex and last edge slot
    add_row(MODE_CHECK, 2000, any_value());
    add_row(MODE_UNUSED_LO, 0, 0);
    add_row(MODE_ROW, INDEX_MAX, 7);
    add_row(MODE_COLOR, MAX_VERTICES, 0);
    add_row(MODE_ROW, 0, 16'h4000);
    add_row(MODE_ROW, 1, 1);
    add_row(MODE_ROW, 2, 3);
    add_row(MODE_ROW, 3, 4);
    add_row(MODE_ADJ, 0, 16'h7C01);
    add_row(MODE_ADJ, 1, 0);
    add_row(MODE_ADJ, 2, 2);
    add_row(MODE_ADJ, 3, 1);
    add_row(MODE_COLOR, 0, 5);
    add_row(MODE_COLOR, 1, ALL_ONES);
    add_row(MODE_COLOR, 2, 5);
    add_row(MODE_CHECK, 2, 0);
    add_row(MODE_CHECK, 2, 0);
    add_row(MODE_CHECK, 0, 0);
    add_row(MODE_START, 0, 0);
    add_row(MODE_CHECK, 1, 0, 1'b1, '{count: 11'd0, conflict: 1'b0, vertex: 10'd1});
    add_row(MODE_ROW, MAX_VERTICES - 1, VALUE_W'(MAX_EDGES - 1));
    add_row(MODE_ROW, MAX_VERTICES, ALL_ONES);
    add_row(MODE_ADJ, MAX_EDGES - 1, ALL_ONES);
    add_row(MODE_COLOR, MAX_VERTICES - 1, VALUE_W'(VALUE_MAX));
    add_row(MODE_CHECK, MAX_VERTICES - 1, 0, 1'b1,
            '{count: 11'd0, conflict: 1'b0, vertex: 10'd1023});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stimulus_rows[i])
      send_item(stimulus_rows[i].mode, stimulus_rows[i].index, stimulus_rows[i].value,
                stimulus_rows[i].typed, stimulus_rows[i].result);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = TX_IDLE[phase];
      rx_idle_pct = RX_IDLE[phase];
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        run_block($urandom_range(9) == 0, phase == 0 && blk == 2);
        if ($urandom_range(3) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_checks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/d2cc_pkg.sv
rtl/d2cc_ram.sv
rtl/d2cc_ctrl.sv
rtl/distance2_coloring_conflict_check_unit.sv
test/tb_top.sv
